// ----- rtl/kbsc_pkg.sv -----
// Shared types, register codes and byte-lane functions for the keyed byte stream cipher.
package kbsc_pkg;

  localparam int KeyBytes   = 32;
  localparam int NonceBytes = 12;
  localparam int NonceLast  = 11;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_PART0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PART1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PART2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PART3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_HIGH = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION  = 3'd6;

  typedef logic [KeyBytes-1:0][7:0]   key_t;
  typedef logic [NonceBytes-1:0][7:0] nonce_t;
  typedef logic [4:0]                 key_idx_t;
  typedef logic [3:0]                 nonce_idx_t;

  typedef struct packed {
    logic [7:0]  data_in;
    logic [15:0] byte_position;
    logic        message_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_out;
  } out_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] wdata;
  } cfg_beat_t;

  // state loaded on the first byte of a message
  typedef struct packed {
    key_t       key;
    nonce_t     nonce;
    logic [7:0] ksum;
    logic [7:0] nsum;
    logic       decrypt;
  } preload_t;

  // nonce[i] += key[i] + key[i+12] + key[(i+24) mod 32]
  function automatic nonce_t mix_round(input nonce_t n, input key_t k);
    nonce_t r;
    for (int i = 0; i < NonceBytes; i++) begin
      r[i] = n[i] + k[i] + k[i+12] + k[(i + 24) % KeyBytes];
    end
    return r;
  endfunction

  function automatic logic [7:0] key_sum(input key_t k);
    logic [15:0][7:0] l1;
    logic [7:0][7:0]  l2;
    logic [3:0][7:0]  l3;
    for (int i = 0; i < 16; i++) l1[i] = k[2*i] + k[2*i+1];
    for (int i = 0; i < 8; i++)  l2[i] = l1[2*i] + l1[2*i+1];
    for (int i = 0; i < 4; i++)  l3[i] = l2[2*i] + l2[2*i+1];
    return (l3[0] + l3[1]) + (l3[2] + l3[3]);
  endfunction

  function automatic logic [7:0] nonce_byte_total(input nonce_t n);
    logic [5:0][7:0] l1;
    for (int i = 0; i < 6; i++) l1[i] = n[2*i] + n[2*i+1];
    return (l1[0] + l1[1]) + (l1[2] + l1[3]) + (l1[4] + l1[5]);
  endfunction

  // position mod 12 through mod 3 and mod 4 residues
  function automatic nonce_idx_t pos_mod12(input logic [15:0] p);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [1:0] m3;
    logic [1:0] m4;
    logic [2:0] diff;
    logic [1:0] k;
    s1 = '0;
    for (int i = 0; i < 8; i++) s1 = s1 + 5'(p[2*i +: 2]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    if (s2 >= 3'd6) m3 = 2'(s2 - 3'd6);
    else if (s2 >= 3'd3) m3 = 2'(s2 - 3'd3);
    else m3 = s2[1:0];
    m4 = (p[1:0] == 2'd3) ? 2'd0 : p[1:0];
    diff = 3'(m3) + 3'd3 - 3'(m4);
    k = (diff >= 3'd3) ? 2'(diff - 3'd3) : diff[1:0];
    return {k, 2'b00} + {2'b00, p[1:0]};
  endfunction

endpackage

// ----- rtl/kbsc_chan_if.sv -----
// Valid/ready channel carrying one payload struct per beat.
interface kbsc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/kbsc_cfg.sv -----
// Configuration registers and the registered message-start state derived from them.
module kbsc_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  kbsc_chan_if.sink              cfg_ch,
  output kbsc_pkg::preload_t     pre
);

  kbsc_pkg::key_t   key_cfg_r;
  kbsc_pkg::nonce_t nonce_cfg_r;
  logic             dir_r;
  kbsc_pkg::nonce_t mixed_r;
  logic [7:0]       ksum_r;
  logic [7:0]       nsum_r;
  logic [7:0]       ksum_nxt;
  logic [7:0]       nsum_nxt;
  logic             wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r   <= '0;
      nonce_cfg_r <= '0;
      dir_r       <= 1'b0;
    end else if (wr) begin
      unique case (cfg_ch.payload.reg_index)
        kbsc_pkg::CFG_KEY_PART0:  key_cfg_r[7:0]    <= cfg_ch.payload.wdata;
        kbsc_pkg::CFG_KEY_PART1:  key_cfg_r[15:8]   <= cfg_ch.payload.wdata;
        kbsc_pkg::CFG_KEY_PART2:  key_cfg_r[23:16]  <= cfg_ch.payload.wdata;
        kbsc_pkg::CFG_KEY_PART3:  key_cfg_r[31:24]  <= cfg_ch.payload.wdata;
        kbsc_pkg::CFG_NONCE_LOW:  nonce_cfg_r[7:0]  <= cfg_ch.payload.wdata;
        kbsc_pkg::CFG_NONCE_HIGH: nonce_cfg_r[11:8] <= cfg_ch.payload.wdata[31:0];
        kbsc_pkg::CFG_DIRECTION:  dir_r             <= cfg_ch.payload.wdata[0];
        default: ;
      endcase
    end
  end

  // mixed nonce sum = raw nonce sum + all key bytes + key bytes 0..3 a second time
  assign ksum_nxt = kbsc_pkg::key_sum(key_cfg_r);
  assign nsum_nxt = kbsc_pkg::nonce_byte_total(nonce_cfg_r) + ksum_nxt
                  + (key_cfg_r[0] + key_cfg_r[1]) + (key_cfg_r[2] + key_cfg_r[3]);

  always_ff @(posedge clk) begin
    mixed_r <= kbsc_pkg::mix_round(nonce_cfg_r, key_cfg_r);
    ksum_r  <= ksum_nxt;
    nsum_r  <= nsum_nxt;
  end

  assign pre.key     = key_cfg_r;
  assign pre.nonce   = mixed_r;
  assign pre.ksum    = ksum_r;
  assign pre.nsum    = nsum_r;
  assign pre.decrypt = dir_r;

endmodule

// ----- rtl/keyed_byte_stream_cipher.sv -----
// Keyed byte stream cipher: one byte in, one byte out, state updated per beat.
// Each accepted beat passes through the input register and then the output register and
// gives exactly one output beat. A new beat can be taken every clock while the sink is
// ready (one byte per cycle sustained), as set by the single state-update stage between
// them, carrying the 32-byte key and 12-byte nonce to the next byte. The output register
// holds a finished byte while the sink stalls and the input register fills behind it,
// so upstream sees backpressure only when both are occupied. Key and nonce registers
// take effect at the next byte flagged message_start; direction applies to every byte.
// Configuration beats are always accepted and must be written while the block is idle;
// the first data beat may follow the write on the next clock.
module keyed_byte_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  kbsc_chan_if.sink  in_ch,
  kbsc_chan_if.source out_ch,
  kbsc_chan_if.sink  cfg_ch
);

  kbsc_pkg::preload_t   pre;

  logic                 s1_valid_r;
  logic [7:0]           s1_din_r;
  kbsc_pkg::key_idx_t   s1_ki_r;
  kbsc_pkg::nonce_idx_t s1_ni_r;
  logic                 s1_start_r;

  kbsc_pkg::key_t       key_r;
  kbsc_pkg::nonce_t     nonce_r;
  logic [7:0]           ksum_r;
  logic [7:0]           nsum_r;

  logic                 out_valid_r;
  logic [7:0]           out_data_r;

  logic                 in_acc;
  logic                 adv;
  kbsc_pkg::key_t       cur_key;
  kbsc_pkg::nonce_t     cur_nonce;
  logic [7:0]           cur_ksum;
  logic [7:0]           cur_nsum;
  logic [7:0]           kb;
  logic [7:0]           ks;
  logic [7:0]           dout;
  logic [7:0]           cipher;
  kbsc_pkg::key_t       key_nxt;
  kbsc_pkg::nonce_t     nonce_nxt;

  kbsc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .pre    (pre)
  );

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_din_r   <= in_ch.payload.data_in;
      s1_ki_r    <= in_ch.payload.byte_position[4:0];
      s1_ni_r    <= kbsc_pkg::pos_mod12(in_ch.payload.byte_position);
      s1_start_r <= in_ch.payload.message_start;
    end
  end

  always_comb begin
    cur_key   = s1_start_r ? pre.key   : key_r;
    cur_nonce = s1_start_r ? pre.nonce : nonce_r;
    cur_ksum  = s1_start_r ? pre.ksum  : ksum_r;
    cur_nsum  = s1_start_r ? pre.nsum  : nsum_r;
    kb        = cur_key[s1_ki_r];
    ks        = cur_ksum + cur_nsum + kb + cur_nonce[s1_ni_r];
    dout      = pre.decrypt ? (s1_din_r - ks) : (s1_din_r + ks);
    cipher    = pre.decrypt ? s1_din_r : dout;
    key_nxt   = cur_key;
    key_nxt[s1_ki_r] = kb + cipher + cur_nonce[kbsc_pkg::NonceLast] + cur_nsum;
    nonce_nxt = kbsc_pkg::mix_round(cur_nonce, key_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
      ksum_r  <= '0;
      nsum_r  <= '0;
    end else if (adv) begin
      key_r   <= key_nxt;
      nonce_r <= nonce_nxt;
      ksum_r  <= cur_ksum;
      nsum_r  <= cur_nsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= dout;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.payload.data_out = out_data_r;

`ifndef ASSERT_OFF
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("output register not loaded after a processed beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without both stages full");

  a_start_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_start_r) |=> (ksum_r == $past(pre.ksum) && nsum_r == $past(pre.nsum)))
    else $error("message start did not latch the preload sums");

  a_nonce_idx: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_ni_r < 4'd12))
    else $error("nonce index out of range");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && $past(rst_n)) |=> ($stable(key_r) && $stable(nonce_r)))
    else $error("cipher state changed without a processed beat");
`endif

endmodule
